// ===== rtl/core/spwc_pkg.sv =====
// Shared types and constants for the servo pulse width capture block.
// No dependencies; imported by servo_pulse_width_capture_top.
`default_nettype none

package spwc_pkg;

   localparam int unsigned CHANNELS    = 4;
   localparam int unsigned CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned TIME_W      = 16;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [TIME_W-1:0] MIN_PULSE_RESET = 16'd400;
   localparam logic [TIME_W-1:0] MAX_PULSE_RESET = 16'd3000;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_PULSE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PULSE = 1'd1;

   // command codes
   localparam logic CMD_CAPTURE = 1'b0;
   localparam logic CMD_READ    = 1'b1;

   typedef struct packed {
      logic              command;
      logic [1:0]        channel;
      logic [TIME_W-1:0] capture_time;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]        channel_out;
      logic              arm_falling;
      logic              pulse_valid;
      logic [TIME_W-1:0] pulse_width;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== rtl/core/servo_pulse_width_capture_top.sv =====
// Servo pulse width capture: per-channel edge pairing, width check, result register.
// A transaction's result is registered, valid in the cycle after its acceptance.
// Throughput: one transaction per cycle unless a held result stalls; per-channel
// state is in flip-flops updated in the accept cycle; the next item sees it at once.
// Reset (synchronous, active high): all channels wait for a rising edge, no fresh
// width, no valid width, thresholds back to 400 and 3000, result register empty.
`default_nettype none

module servo_pulse_width_capture_top (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire spwc_pkg::req_payload_type req_payload,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output spwc_pkg::rsp_payload_type    rsp_payload,
   input  wire                          csr_we,
   input  wire [spwc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire [spwc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import spwc_pkg::*;

   logic [TIME_W-1:0] min_pulse_ff;
   logic [TIME_W-1:0] max_pulse_ff;

   logic [CHANNELS-1:0] waiting_fall_ff, waiting_fall_in;
   logic [CHANNELS-1:0] fresh_ff, fresh_in;
   logic [CHANNELS-1:0] width_ok_ff, width_ok_in;
   logic [TIME_W-1:0]   rise_stamp_ff     [CHANNELS];
   logic [TIME_W-1:0]   raw_width_ff      [CHANNELS];
   logic [TIME_W-1:0]   accepted_width_ff [CHANNELS];

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_payload_ff, rsp_payload_in;

   logic                req_fire;
   logic                ch_in_range;
   logic [CH_IDX_W-1:0] ch_idx;
   logic                is_read;
   logic                cur_wf;
   logic                cur_fresh;
   logic                cur_ok;
   logic [TIME_W-1:0]   cur_acc;
   logic [TIME_W-1:0]   cur_raw;
   logic [TIME_W-1:0]   fall_width;
   logic                in_window;
   logic                read_ok;
   logic [TIME_W-1:0]   read_width;
   logic                rise_we, fall_we, accept_we;

   assign req_ready = rsp_ready || !rsp_valid_ff;
   assign req_fire  = req_valid && req_ready;

   assign ch_in_range = (32'(req_payload.channel) < CHANNELS);
   assign ch_idx      = CH_IDX_W'(req_payload.channel);
   assign is_read     = (req_payload.command == CMD_READ);

   assign cur_wf     = waiting_fall_ff[ch_idx];
   assign cur_fresh  = fresh_ff[ch_idx];
   assign cur_ok     = width_ok_ff[ch_idx];
   assign cur_acc    = accepted_width_ff[ch_idx];
   assign cur_raw    = raw_width_ff[ch_idx];
   assign fall_width = req_payload.capture_time - rise_stamp_ff[ch_idx];
   assign in_window  = (cur_raw > min_pulse_ff) && (cur_raw < max_pulse_ff);

   always_comb begin
      read_ok    = cur_ok;
      read_width = cur_acc;
      if (cur_fresh) begin
         read_ok = in_window;
         if (in_window) begin
            read_width = cur_raw;
         end
      end
   end

   assign rise_we   = req_fire && ch_in_range && !is_read && !cur_wf;
   assign fall_we   = req_fire && ch_in_range && !is_read && cur_wf;
   assign accept_we = req_fire && ch_in_range && is_read && cur_fresh && in_window;

   always_comb begin
      waiting_fall_in = waiting_fall_ff;
      fresh_in        = fresh_ff;
      width_ok_in     = width_ok_ff;
      if (req_fire && ch_in_range) begin
         if (is_read) begin
            // settle a fresh width against the window, then drop fresh
            if (cur_fresh) begin
               width_ok_in[ch_idx] = in_window;
               fresh_in[ch_idx]    = 1'b0;
            end
         end else begin
            waiting_fall_in[ch_idx] = !cur_wf;
            if (cur_wf) begin
               fresh_in[ch_idx] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (req_fire) begin
         rsp_valid_in               = 1'b1;
         rsp_payload_in.channel_out = req_payload.channel;
         rsp_payload_in.arm_falling = 1'b0;
         rsp_payload_in.pulse_valid = 1'b0;
         rsp_payload_in.pulse_width = '0;
         if (ch_in_range) begin
            if (is_read) begin
               rsp_payload_in.arm_falling = cur_wf;
               rsp_payload_in.pulse_valid = read_ok;
               rsp_payload_in.pulse_width = read_ok ? read_width : '0;
            end else begin
               rsp_payload_in.arm_falling = !cur_wf;
            end
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_pulse_ff    <= MIN_PULSE_RESET;
         max_pulse_ff    <= MAX_PULSE_RESET;
         waiting_fall_ff <= '0;
         fresh_ff        <= '0;
         width_ok_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            accepted_width_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_MIN_PULSE: min_pulse_ff <= TIME_W'(csr_wdata);
               CSR_MAX_PULSE: max_pulse_ff <= TIME_W'(csr_wdata);
               default: ;
            endcase
         end
         waiting_fall_ff <= waiting_fall_in;
         fresh_ff        <= fresh_in;
         width_ok_ff     <= width_ok_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (accept_we) begin
            accepted_width_ff[ch_idx] <= cur_raw;
         end
      end
   end

   // timestamps and raw widths need no reset
   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      if (rise_we) begin
         rise_stamp_ff[ch_idx] <= req_payload.capture_time;
      end
      if (fall_we) begin
         raw_width_ff[ch_idx] <= fall_width;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // a read leaves its channel without a fresh width
   a_read_clears_fresh: assert property (@(posedge clock) disable iff (reset)
      (req_fire && ch_in_range && is_read) |=> !fresh_ff[$past(ch_idx)])
      else $error("fresh flag survived a read");

   // a capture reports the polarity the channel is now armed for
   a_capture_arm: assert property (@(posedge clock) disable iff (reset)
      (req_fire && ch_in_range && !is_read) |=>
         (rsp_valid_ff && rsp_payload_ff.arm_falling == waiting_fall_ff[$past(ch_idx)]))
      else $error("capture result disagrees with channel polarity");

   // a falling capture always produces a fresh width
   a_fall_sets_fresh: assert property (@(posedge clock) disable iff (reset)
      fall_we |=> fresh_ff[$past(ch_idx)])
      else $error("falling edge did not mark width fresh");

   // a width is reported only with the valid flag
   a_width_needs_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.pulse_width != '0) |-> rsp_payload_ff.pulse_valid)
      else $error("nonzero width reported without valid");

endmodule

`default_nettype wire

// ===== verif/servo_pulse_width_capture_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for servo_pulse_width_capture_top: directed edge pairs, then random
// pulse trains under several threshold settings, with random stalls on both channels.
// Depends on spwc_pkg and servo_pulse_width_capture_top.

import spwc_pkg::*;

class capture_tracker;
   logic [TIME_W-1:0] lo_bound;
   logic [TIME_W-1:0] hi_bound;
   logic              armed_fall [CHANNELS];
   logic [TIME_W-1:0] rise_at    [CHANNELS];
   logic [TIME_W-1:0] last_raw   [CHANNELS];
   logic              has_new    [CHANNELS];
   logic [TIME_W-1:0] kept_width [CHANNELS];
   logic              in_window  [CHANNELS];
   rsp_payload_type   due_rsps [$];
   int                errors;

   function new();
      lo_bound = MIN_PULSE_RESET;
      hi_bound = MAX_PULSE_RESET;
      errors = 0;
      for (int i = 0; i < CHANNELS; i++) begin
         armed_fall[i] = 1'b0;
         rise_at[i]    = '0;
         last_raw[i]   = '0;
         has_new[i]    = 1'b0;
         kept_width[i] = '0;
         in_window[i]  = 1'b0;
      end
   endfunction

   function void set_bounds(logic [TIME_W-1:0] lo, logic [TIME_W-1:0] hi);
      lo_bound = lo;
      hi_bound = hi;
   endfunction

   // Advance the per-channel state for one accepted request and queue its response.
   function void note_request(req_payload_type r);
      rsp_payload_type e;
      int unsigned     c;
      c = 32'(r.channel);
      e = '0;
      e.channel_out = r.channel;
      if (c < CHANNELS) begin
         if (r.command == CMD_CAPTURE) begin
            if (!armed_fall[c]) begin
               rise_at[c]    = r.capture_time;
               armed_fall[c] = 1'b1;
            end else begin
               last_raw[c]   = r.capture_time - rise_at[c];
               has_new[c]    = 1'b1;
               armed_fall[c] = 1'b0;
            end
         end else begin
            if (has_new[c]) begin
               if (last_raw[c] > lo_bound && last_raw[c] < hi_bound) begin
                  kept_width[c] = last_raw[c];
                  in_window[c]  = 1'b1;
               end else begin
                  in_window[c]  = 1'b0;
               end
               has_new[c] = 1'b0;
            end
            e.pulse_valid = in_window[c];
            e.pulse_width = in_window[c] ? kept_width[c] : '0;
         end
         e.arm_falling = armed_fall[c];
      end
      due_rsps.push_back(e);
   endfunction

   function int pending();
      return due_rsps.size();
   endfunction

   task report(string what);
      if (errors < 100)
         $display("mismatch: %s", what);
      errors++;
   endtask

   task check_response(rsp_payload_type got);
      rsp_payload_type e;
      if (due_rsps.size() == 0) begin
         report($sformatf("response %h with nothing outstanding", got));
      end else begin
         e = due_rsps.pop_front();
         if (got.channel_out !== e.channel_out)
            report($sformatf("channel_out %0d, want %0d", got.channel_out, e.channel_out));
         if (got.arm_falling !== e.arm_falling)
            report($sformatf("ch %0d arm_falling %b, want %b", e.channel_out,
                             got.arm_falling, e.arm_falling));
         if (got.pulse_valid !== e.pulse_valid)
            report($sformatf("ch %0d pulse_valid %b, want %b", e.channel_out,
                             got.pulse_valid, e.pulse_valid));
         if (got.pulse_width !== e.pulse_width)
            report($sformatf("ch %0d pulse_width %0d, want %0d", e.channel_out,
                             got.pulse_width, e.pulse_width));
      end
   endtask
endclass

module servo_pulse_width_capture_top_test;

   localparam int CYCLE_LIMIT = 900000;
   localparam int PHASE_ITEMS = 235;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_MIN_PULSE;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   capture_tracker tracker = new();
   bit             gen_fall [CHANNELS];
   bit             steady = 1'b0;
   int             stall_left = 0;
   int             cycle_count = 0;

   servo_pulse_width_capture_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (!rsp_ready) begin
         rsp_ready <= 1'b1;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= pick_gap();
      end
   end

   // Note requests before checking responses so a same-edge pair stays ordered.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            tracker.note_request(req_payload);
         if (rsp_valid && rsp_ready)
            tracker.check_response(rsp_payload);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("servo_pulse_width_capture_top_test: errors");
         $finish;
      end
   end

   // Present one transaction and hold it until accepted.
   task automatic send_item(logic cmd, int ch, logic [TIME_W-1:0] stamp);
      req_payload_type p;
      int              gap;
      p.command      = cmd;
      p.channel      = ch[1:0];
      p.capture_time = stamp;
      gap = steady ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (cmd == CMD_CAPTURE)
         gen_fall[ch] = !gen_fall[ch];
   endtask

   // Drain every outstanding response; the first edge lets the monitor note the last request.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_bounds(logic [TIME_W-1:0] lo, logic [TIME_W-1:0] hi);
      csr_we    <= 1'b1;
      csr_index <= CSR_MIN_PULSE;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_MAX_PULSE;
      csr_wdata <= hi;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.set_bounds(lo, hi);
   endtask

   task automatic run_phase(int n_items);
      int                ch;
      int                done;
      int                pick;
      logic [TIME_W-1:0] t0;
      logic [TIME_W-1:0] w;
      logic [TIME_W-1:0] lo;
      logic [TIME_W-1:0] hi;
      lo = tracker.lo_bound;
      hi = tracker.hi_bound;
      done = 0;
      while (done < n_items) begin
         if ($urandom_range(0, 9) == 0) begin
            // noise: any command, channel and stamp
            send_item(1'($urandom_range(0, 1)), $urandom_range(0, CHANNELS - 1),
                      TIME_W'($urandom));
            done++;
         end else begin
            ch = $urandom_range(0, CHANNELS - 1);
            // close a dangling pulse first with a stray falling edge
            if (gen_fall[ch]) begin
               send_item(CMD_CAPTURE, ch, TIME_W'($urandom));
               done++;
            end
            pick = $urandom_range(0, 9);
            case (pick)
               0: w = lo - 1'b1;
               1: w = lo;
               2: w = lo + 1'b1;
               3: w = hi - 1'b1;
               4: w = hi;
               5: w = hi + 1'b1;
               6, 7: w = (hi > lo + 1) ? TIME_W'($urandom_range(lo + 1, hi - 1))
                                       : TIME_W'($urandom);
               8: w = $urandom_range(0, 1) ? TIME_W'($urandom_range(0, 3))
                                           : TIME_W'($urandom_range(65532, 65535));
               default: w = TIME_W'($urandom);
            endcase
            t0 = TIME_W'($urandom);
            send_item(CMD_CAPTURE, ch, t0);
            if ($urandom_range(0, 3) == 0) begin
               send_item(CMD_READ, $urandom_range(0, CHANNELS - 1), TIME_W'($urandom));
               done++;
            end
            send_item(CMD_CAPTURE, ch, t0 + w);
            done += 2;
            if ($urandom_range(0, 4) != 0) begin
               send_item(CMD_READ, ch, TIME_W'($urandom));
               done++;
            end
         end
      end
   endtask

   initial begin
      logic [TIME_W-1:0] lo_set [8];
      logic [TIME_W-1:0] hi_set [8];
      lo_set = '{16'd0, 16'd65535, 16'd1000, 16'd1000, 16'd0, 16'd0, 16'd400, 16'd0};
      hi_set = '{16'd65535, 16'd0, 16'd1001, 16'd1002, 16'd0, 16'd2, 16'd3000, 16'd0};
      lo_set[7] = TIME_W'($urandom_range(0, 5000));
      hi_set[7] = lo_set[7] + 16'($urandom_range(0, 4000));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed edge pairs at the reset thresholds
      send_item(CMD_READ,    0, 16'd0);
      send_item(CMD_CAPTURE, 0, 16'd0);
      send_item(CMD_CAPTURE, 0, 16'd1000);
      send_item(CMD_READ,    0, 16'hFFFF);
      send_item(CMD_READ,    0, 16'd0);
      send_item(CMD_CAPTURE, 1, 16'hFFFF);
      send_item(CMD_CAPTURE, 1, 16'd999);
      send_item(CMD_READ,    1, 16'd0);
      send_item(CMD_CAPTURE, 2, 16'd100);
      send_item(CMD_CAPTURE, 2, 16'd500);
      send_item(CMD_READ,    2, 16'd0);
      send_item(CMD_CAPTURE, 2, 16'd0);
      send_item(CMD_CAPTURE, 2, 16'd3000);
      send_item(CMD_READ,    2, 16'd0);
      send_item(CMD_CAPTURE, 3, 16'hFFFF);
      send_item(CMD_CAPTURE, 3, 16'hFFFF);
      send_item(CMD_READ,    3, 16'd0);
      send_item(CMD_CAPTURE, 3, 16'd0);
      send_item(CMD_CAPTURE, 3, 16'd401);
      send_item(CMD_CAPTURE, 0, 16'd5);
      send_item(CMD_CAPTURE, 0, 16'd3004);
      send_item(CMD_READ,    3, 16'd0);
      send_item(CMD_READ,    0, 16'd0);
      send_item(CMD_CAPTURE, 1, 16'd0);
      send_item(CMD_CAPTURE, 1, 16'hFFFF);
      send_item(CMD_READ,    1, 16'd0);
      settle();

      for (int ph = 0; ph < 8; ph++) begin
         program_bounds(lo_set[ph], hi_set[ph]);
         steady = ($urandom_range(0, 3) == 0);
         run_phase(PHASE_ITEMS);
         settle();
      end

      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("servo_pulse_width_capture_top_test: clean");
      else
         $display("servo_pulse_width_capture_top_test: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/spwc_pkg.sv
rtl/core/servo_pulse_width_capture_top.sv
verif/servo_pulse_width_capture_top_test.sv
